[hw/rtl/kalman_filter_three_state_defines.svh]
// ----------------------------------------------------------------------------
// Kalman filter assertion macros
// Concurrent assertion wrappers shared by the filter RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef KALMAN_FILTER_THREE_STATE_DEFINES_SVH
`define KALMAN_FILTER_THREE_STATE_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define KF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("kalman filter assertion failed");
// Check that post holds in the cycle after pre.
`define KF_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("kalman filter sequencing assertion failed");
`else
`define KF_ASSERT(lbl, prop)
`define KF_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

[hw/rtl/kf3_pkg.sv]
// ----------------------------------------------------------------------------
// Kalman filter package
// Fixed-point constants, operand memory map, sequencer program and helpers.
// ----------------------------------------------------------------------------
package kf3_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int STATE_COUNT = 3;

	localparam int N  = STATE_COUNT;
	localparam int NN = N * N;

	// Model and state slots follow the load slot numbering
	localparam int SLOT_A      = 0;
	localparam int SLOT_C      = NN;
	localparam int SLOT_Q      = NN + N;
	localparam int SLOT_G      = 2 * NN + N;
	localparam int SLOT_R      = 3 * NN + N;
	localparam int MODEL_DEPTH = 3 * NN + N + 1;
	localparam int SLOT_X      = MODEL_DEPTH;
	localparam int SLOT_P      = SLOT_X + N;
	localparam int SLOT_END    = SLOT_P + NN;

	// Scratch operands
	localparam int T_Z    = SLOT_END;
	localparam int T_XP   = T_Z + 1;
	localparam int T_AP   = T_XP + N;
	localparam int T_APAT = T_AP + NN;
	localparam int T_GQ   = T_APAT + NN;
	localparam int T_GQG  = T_GQ + NN;
	localparam int T_PP   = T_GQG + NN;
	localparam int T_CX   = T_PP + NN;
	localparam int T_Y    = T_CX + 1;
	localparam int T_CP   = T_Y + 1;
	localparam int T_CPC  = T_CP + N;
	localparam int T_S    = T_CPC + 1;
	localparam int T_PCT  = T_S + 1;
	localparam int T_KG   = T_PCT + N;
	localparam int T_KY   = T_KG + N;
	localparam int T_KC   = T_KY + N;
	localparam int T_IKC  = T_KC + NN;
	localparam int MEM_DEPTH = T_IKC + NN;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	localparam int STR_W = $clog2(N + 1);
	localparam int CNT_W = $clog2(NN + 1);
	localparam int PC_W  = 5;

	localparam int ACC_W = 64 - FRAC_BITS + 3;
	localparam int DIV_W = 32 + FRAC_BITS;
	localparam int DCNT_W = $clog2(DIV_W);

	localparam logic [PC_W-1:0] PC_COPY = PC_W'(20);
	localparam logic [PC_W-1:0] PC_LAST = PC_W'(22);

	typedef enum logic [2:0] {
		OP_MUL, OP_ADD, OP_SUB, OP_ISUB, OP_COPY, OP_DIV, OP_BR, OP_END
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DEC, ST_RD, ST_EX, ST_DIV, ST_AC, ST_WR
	} st_t;

	// One sequencer step: element loop r x c, term loop k, strided operands
	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] abase;
		logic [STR_W-1:0]  ai;
		logic [STR_W-1:0]  aj;
		logic [STR_W-1:0]  am;
		logic [ADDR_W-1:0] bbase;
		logic [STR_W-1:0]  bi;
		logic [STR_W-1:0]  bj;
		logic [STR_W-1:0]  bm;
		logic [ADDR_W-1:0] dbase;
		logic [CNT_W-1:0]  r;
		logic [CNT_W-1:0]  c;
		logic [CNT_W-1:0]  k;
	} instr_t;

	function automatic instr_t mk(op_t op, int ab, int ai, int aj, int am,
			int bb, int bi, int bj, int bm, int db, int r, int c, int k);
		instr_t t;
		t.op    = op;
		t.abase = ADDR_W'(ab);
		t.ai    = STR_W'(ai);
		t.aj    = STR_W'(aj);
		t.am    = STR_W'(am);
		t.bbase = ADDR_W'(bb);
		t.bi    = STR_W'(bi);
		t.bj    = STR_W'(bj);
		t.bm    = STR_W'(bm);
		t.dbase = ADDR_W'(db);
		t.r     = CNT_W'(r);
		t.c     = CNT_W'(c);
		t.k     = CNT_W'(k);
		return t;
	endfunction

	// Predict, innovate, branch on S, then correct or copy the prediction
	function automatic instr_t prog(logic [PC_W-1:0] pc);
		instr_t t;
		t = mk(OP_END, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1);
		unique case (pc)
			5'd0:  t = mk(OP_MUL, SLOT_A, N, 0, 1, SLOT_X, 0, 0, 1, T_XP, N, 1, N);
			5'd1:  t = mk(OP_MUL, SLOT_A, N, 0, 1, SLOT_P, 0, 1, N, T_AP, N, N, N);
			5'd2:  t = mk(OP_MUL, T_AP, N, 0, 1, SLOT_A, 0, N, 1, T_APAT, N, N, N);
			5'd3:  t = mk(OP_MUL, SLOT_G, N, 0, 1, SLOT_Q, 0, 1, N, T_GQ, N, N, N);
			5'd4:  t = mk(OP_MUL, T_GQ, N, 0, 1, SLOT_G, 0, N, 1, T_GQG, N, N, N);
			5'd5:  t = mk(OP_ADD, T_APAT, 0, 1, 0, T_GQG, 0, 1, 0, T_PP, 1, NN, 1);
			5'd6:  t = mk(OP_MUL, SLOT_C, 0, 0, 1, T_XP, 0, 0, 1, T_CX, 1, 1, N);
			5'd7:  t = mk(OP_SUB, T_Z, 0, 0, 0, T_CX, 0, 0, 0, T_Y, 1, 1, 1);
			5'd8:  t = mk(OP_MUL, SLOT_C, 0, 0, 1, T_PP, 0, 1, N, T_CP, 1, N, N);
			5'd9:  t = mk(OP_MUL, T_CP, 0, 0, 1, SLOT_C, 0, 0, 1, T_CPC, 1, 1, N);
			5'd10: t = mk(OP_ADD, T_CPC, 0, 0, 0, SLOT_R, 0, 0, 0, T_S, 1, 1, 1);
			5'd11: t = mk(OP_BR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1);
			5'd12: t = mk(OP_MUL, T_PP, N, 0, 1, SLOT_C, 0, 0, 1, T_PCT, N, 1, N);
			5'd13: t = mk(OP_DIV, T_PCT, 1, 0, 0, 0, 0, 0, 0, T_KG, N, 1, 1);
			5'd14: t = mk(OP_MUL, T_KG, 1, 0, 0, T_Y, 0, 0, 0, T_KY, N, 1, 1);
			5'd15: t = mk(OP_ADD, T_KY, 1, 0, 0, T_XP, 1, 0, 0, SLOT_X, N, 1, 1);
			5'd16: t = mk(OP_MUL, T_KG, 1, 0, 0, SLOT_C, 0, 1, 0, T_KC, N, N, 1);
			5'd17: t = mk(OP_ISUB, T_KC, N, 1, 0, 0, 0, 0, 0, T_IKC, N, N, 1);
			5'd18: t = mk(OP_MUL, T_IKC, N, 0, 1, T_PP, 0, 1, N, SLOT_P, N, N, N);
			5'd20: t = mk(OP_COPY, T_XP, 0, 1, 0, 0, 0, 0, 0, SLOT_X, 1, N, 1);
			5'd21: t = mk(OP_COPY, T_PP, 0, 1, 0, 0, 0, 0, 0, SLOT_P, 1, NN, 1);
			default: t = mk(OP_END, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1);
		endcase
		return t;
	endfunction

	// Clamp an accumulator to 32 signed bits
	function automatic logic signed [31:0] sat_acc(logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(64'sh7FFF_FFFF);
		lo = ~hi;
		if (v > hi) begin
			return 32'sh7FFF_FFFF;
		end else if (v < lo) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

endpackage

[hw/rtl/kalman_filter_three_state.sv]
// ----------------------------------------------------------------------------
// Three-state Kalman filter
// Q16.16 linear Kalman filter with scalar measurement, run by a microcoded
// sequencer around one shared multiply-accumulate unit and a serial divider.
// ----------------------------------------------------------------------------
//  channel | signals                                        | role
//  in      | in_valid, in_stall, mode, coef_index,          | load or measurement
//          | coef_value, measurement                        |
//  out     | out_valid, out_stall, estimate_first/second/   | estimates, status
//          | third, update_status                           |
//
//  A load beat is taken without stalling the input. A measurement beat runs the
//  program: one decode per step, a read, multiply and accumulate per product
//  term through the shared multiplier, a write per written element, and a run
//  of the serial divider per gain element. The input stalls for the whole run.
//  Reset clears the model, state and covariance. The finished beat waits in the
//  output register; the run holds at its end while a previous result is still
//  stalled.
// ----------------------------------------------------------------------------
`include "kalman_filter_three_state_defines.svh"

module kalman_filter_three_state
	import kf3_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic [5:0]         coef_index,
	input  logic signed [31:0] coef_value,
	input  logic signed [31:0] measurement,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] estimate_first,
	output logic signed [31:0] estimate_second,
	output logic signed [31:0] estimate_third,
	output logic               update_status
);

	st_t                      state_q, state_d;
	logic [PC_W-1:0]          pc_q;
	logic [CNT_W-1:0]         i_q, j_q, m_q;
	instr_t                   ins;
	logic signed [31:0]       mem_q [MEM_DEPTH];
	logic [MEM_DEPTH-1:0]     vld_q;
	logic signed [31:0]       ra_q, rb_q;
	logic signed [63:0]       prod_q;
	logic signed [ACC_W-1:0]  acc_q, term;
	logic signed [31:0]       s_q;
	logic                     status_q;
	logic [DIV_W-1:0]         div_num_q, div_num_n;
	logic [31:0]              div_rem_q, div_rem_n;
	logic [DCNT_W-1:0]        div_cnt_q;
	logic                     div_neg_q;
	logic [32:0]              rem_sh;
	logic                     div_ge;
	logic signed [31:0]       div_res;
	logic signed [31:0]       est_q [3];
	logic                     out_valid_q, status_out_q;
	logic signed [31:0]       est_out_q [3];
	logic [ADDR_W-1:0]        a_addr, b_addr, d_addr, w_addr;
	logic signed [31:0]       w_data;
	logic                     w_en;
	logic                     load_acc, meas_acc, m_last, wr_last, out_free, out_load;

	assign ins      = prog(pc_q);
	assign in_stall = (state_q != ST_IDLE);
	assign load_acc = in_valid && !in_stall && !mode;
	assign meas_acc = in_valid && !in_stall && mode;
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == ST_DEC) && (ins.op == OP_END) && out_free;

	assign a_addr = ADDR_W'(ins.abase + i_q * ins.ai + j_q * ins.aj + m_q * ins.am);
	assign b_addr = ADDR_W'(ins.bbase + i_q * ins.bi + j_q * ins.bj + m_q * ins.bm);
	assign d_addr = ADDR_W'(ins.dbase + i_q * ins.c + j_q);

	assign m_last  = (m_q == CNT_W'(ins.k - 1'b1));
	assign wr_last = (j_q == CNT_W'(ins.c - 1'b1)) && (i_q == CNT_W'(ins.r - 1'b1));

	// Select the single write port: a load beat, the measurement or a result
	always_comb begin
		w_en   = 1'b0;
		w_addr = '0;
		w_data = '0;
		if (load_acc && (coef_index < 6'(SLOT_END))) begin
			w_en   = 1'b1;
			w_addr = ADDR_W'(coef_index);
			w_data = coef_value;
		end else if (meas_acc) begin
			w_en   = 1'b1;
			w_addr = ADDR_W'(T_Z);
			w_data = measurement;
		end else if (state_q == ST_WR) begin
			w_en   = 1'b1;
			w_addr = d_addr;
			w_data = sat_acc(acc_q);
		end
	end

	// Scale products back to Q format; other ops add as is
	always_comb begin
		if (ins.op == OP_MUL) begin
			term = ACC_W'(prod_q >>> FRAC_BITS);
		end else begin
			term = ACC_W'(prod_q);
		end
	end

	// One restoring divider step and final clamp of the gain
	always_comb begin
		rem_sh    = {div_rem_q, div_num_q[DIV_W-1]};
		div_ge    = (rem_sh >= {1'b0, s_q});
		div_rem_n = div_ge ? 32'(rem_sh - {1'b0, s_q}) : rem_sh[31:0];
		div_num_n = {div_num_q[DIV_W-2:0], div_ge};
		if (div_neg_q) begin
			if (div_num_n > DIV_W'(64'h8000_0000)) begin
				div_res = 32'sh8000_0000;
			end else begin
				div_res = -$signed(div_num_n[31:0]);
			end
		end else begin
			if (div_num_n > DIV_W'(64'h7FFF_FFFF)) begin
				div_res = 32'sh7FFF_FFFF;
			end else begin
				div_res = $signed(div_num_n[31:0]);
			end
		end
	end

	// Next state of the sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (meas_acc) begin
					state_d = ST_DEC;
				end
			end
			ST_DEC: begin
				unique case (ins.op)
					OP_END: begin
						if (out_free) begin
							state_d = ST_IDLE;
						end
					end
					OP_BR:   state_d = ST_DEC;
					default: state_d = ST_RD;
				endcase
			end
			ST_RD: state_d = ST_EX;
			ST_EX: state_d = (ins.op == OP_DIV) ? ST_DIV : ST_AC;
			ST_DIV: begin
				if (div_cnt_q == DCNT_W'(DIV_W - 1)) begin
					state_d = ST_WR;
				end
			end
			ST_AC: state_d = m_last ? ST_WR : ST_RD;
			ST_WR: state_d = wr_last ? ST_DEC : ST_RD;
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers: state, program counter, loop counters, results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pc_q         <= '0;
			i_q          <= '0;
			j_q          <= '0;
			m_q          <= '0;
			s_q          <= '0;
			status_q     <= 1'b0;
			vld_q        <= '0;
			est_q        <= '{default: '0};
			out_valid_q  <= 1'b0;
			status_out_q <= 1'b0;
			est_out_q    <= '{default: '0};
		end else begin
			state_q <= state_d;
			if (w_en) begin
				vld_q[w_addr] <= 1'b1;
			end
			// mirror the state slots for the output
			for (int e = 0; e < 3; e++) begin
				if (w_en && (e < N) && (w_addr == ADDR_W'(SLOT_X + e))) begin
					est_q[e] <= w_data;
				end
			end
			// load the finished beat, or drop the one taken downstream
			if (out_load) begin
				out_valid_q  <= 1'b1;
				status_out_q <= status_q;
				est_out_q    <= est_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					pc_q <= '0;
					i_q  <= '0;
					j_q  <= '0;
					m_q  <= '0;
				end
				ST_DEC: begin
					if (ins.op == OP_BR) begin
						status_q <= s_q[31] || (s_q == '0);
						pc_q     <= (s_q[31] || (s_q == '0)) ? PC_COPY : pc_q + 1'b1;
					end
				end
				ST_AC: begin
					m_q <= m_last ? '0 : m_q + 1'b1;
				end
				ST_WR: begin
					if (d_addr == ADDR_W'(T_S)) begin
						s_q <= w_data;
					end
					// advance over elements, then to the next step
					if (j_q != CNT_W'(ins.c - 1'b1)) begin
						j_q <= j_q + 1'b1;
					end else begin
						j_q <= '0;
						if (i_q != CNT_W'(ins.r - 1'b1)) begin
							i_q <= i_q + 1'b1;
						end else begin
							i_q  <= '0;
							pc_q <= pc_q + 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Operand memory
	always_ff @(posedge clk) begin
		if (w_en) begin
			mem_q[w_addr] <= w_data;
		end
		if (state_q == ST_RD) begin
			ra_q <= vld_q[a_addr] ? mem_q[a_addr] : '0;
			rb_q <= vld_q[b_addr] ? mem_q[b_addr] : '0;
		end
	end

	// Shared arithmetic unit: multiply, add, subtract or copy, accumulate, divide
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				acc_q <= '0;
			end
			ST_EX: begin
				unique case (ins.op)
					OP_MUL:  prod_q <= 64'(ra_q) * 64'(rb_q);
					OP_ADD:  prod_q <= 64'(ra_q) + 64'(rb_q);
					OP_SUB:  prod_q <= 64'(ra_q) - 64'(rb_q);
					OP_ISUB: prod_q <= ((i_q == j_q) ? (64'sd1 <<< FRAC_BITS) : 64'sd0)
						- 64'(ra_q);
					OP_COPY: prod_q <= 64'(ra_q);
					OP_DIV: begin
						div_neg_q <= ra_q[31];
						div_num_q <= DIV_W'(ra_q[31] ? 32'(-ra_q) : 32'(ra_q)) << FRAC_BITS;
						div_rem_q <= '0;
						div_cnt_q <= '0;
					end
					default: prod_q <= '0;
				endcase
			end
			ST_DIV: begin
				div_num_q <= div_num_n;
				div_rem_q <= div_rem_n;
				div_cnt_q <= div_cnt_q + 1'b1;
				if (div_cnt_q == DCNT_W'(DIV_W - 1)) begin
					acc_q <= ACC_W'(div_res);
				end
			end
			ST_AC: begin
				acc_q <= acc_q + term;
			end
			ST_WR: begin
				acc_q <= '0;
			end
			default: begin
			end
		endcase
	end

	assign out_valid       = out_valid_q;
	assign update_status   = status_out_q;
	assign estimate_first  = est_out_q[0];
	assign estimate_second = est_out_q[1];
	assign estimate_third  = est_out_q[2];

	`KF_ASSERT(a_out_rise_idle, $rose(out_valid_q) |-> (state_q == ST_IDLE))
	`KF_ASSERT(a_div_pos_s, (state_q == ST_DIV) |-> (!s_q[31] && (s_q != '0)))
	`KF_ASSERT(a_pc_range, (state_q != ST_IDLE) |-> (pc_q <= PC_LAST))
	`KF_ASSERT_NEXT(a_wr_next_elem, (state_q == ST_WR) && !wr_last, state_q == ST_RD)

endmodule

[tb/sv/tb_kalman_filter_three_state.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kalman filter testbench
// Drives load and measurement beats into the three-state filter, with random
// gaps on both sides and one long output hold-off. A fixed-point model of the
// filter predicts each estimate beat, and a queue holds the expected beats
// until they are compared field by field.
// ----------------------------------------------------------------------------
module tb_kalman_filter_three_state;
	import kf3_pkg::*;

	localparam int IDLE_MAX    = 6;
	localparam int DOG_LIMIT   = 20000;
	localparam int HOLD_CYCLES = 3000;
	localparam int N_RANDOM    = 930;
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_MEAS = 1'b1;
	localparam logic STAT_DONE = 1'b0;
	localparam logic STAT_SKIP = 1'b1;
	localparam logic signed [31:0] ONE  = 32'sh0001_0000;
	localparam logic signed [31:0] QMAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] QMIN = 32'sh8000_0000;

	typedef struct {
		logic               mode;
		logic [5:0]         idx;
		logic signed [31:0] val;
		logic signed [31:0] meas;
	} beat_t;

	typedef struct packed {
		logic signed [31:0] e0, e1, e2;
		logic               status;
	} estimate_t;

	// Directed row: beat plus optional typed-in expectation
	typedef struct {
		beat_t     b;
		bit        typed;
		estimate_t e;
	} row_t;

	logic               clk, arst_n;
	logic               in_valid, in_stall, mode;
	logic [5:0]         coef_index;
	logic signed [31:0] coef_value, measurement;
	logic               out_valid, out_stall;
	logic signed [31:0] estimate_first, estimate_second, estimate_third;
	logic               update_status;

	kalman_filter_three_state dut (.*);

	// Filter model state
	logic signed [31:0] mdl [MODEL_DEPTH];
	logic signed [31:0] xv [N];
	logic signed [31:0] pm [NN];

	estimate_t expected_q [$];
	beat_t     stim_q [$];
	int  errors = 0;
	int  dog = 0;
	int  n_accept = 0;
	bit  stim_done = 0;
	bit  hold_req = 0;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic logic signed [31:0] sat(longint v);
		if (v > longint'(QMAX)) return QMAX;
		if (v < longint'(QMIN)) return QMIN;
		return v[31:0];
	endfunction

	// Product shifted down with floor rounding
	function automatic longint fmul(logic signed [31:0] a, logic signed [31:0] b);
		longint p;
		p = longint'(a) * longint'(b);
		return p >>> FRAC_BITS;
	endfunction

	// out[r x c] = a[r x k] * b[k x c]
	function automatic void mmul(input logic signed [31:0] a [], input logic signed [31:0] b [],
			output logic signed [31:0] o [], input int r, input int k, input int c);
		longint acc;
		o = new[r * c];
		for (int i = 0; i < r; i++)
			for (int j = 0; j < c; j++) begin
				acc = 0;
				for (int m = 0; m < k; m++) acc += fmul(a[i*k+m], b[m*c+j]);
				o[i*c+j] = sat(acc);
			end
	endfunction

	function automatic void slice(input int base, input int len,
			output logic signed [31:0] o []);
		o = new[len];
		for (int i = 0; i < len; i++) o[i] = mdl[base+i];
	endfunction

	// Apply one beat to the model; return 1 with the estimate on a measurement
	function automatic bit filter_step(beat_t b, output estimate_t e);
		logic signed [31:0] a [], at [], c [], q [], g [], gt [], x [], p [];
		logic signed [31:0] xp [], ap [], apat [], gq [], gqg [], pp [];
		logic signed [31:0] cx [], cp [], cpc [], pct [], kg [], kc [], ikc [], np [];
		logic signed [31:0] y, s;
		longint num;
		if (b.mode == MODE_LOAD) begin
			if (b.idx < MODEL_DEPTH) mdl[b.idx] = b.val;
			else if (b.idx < SLOT_P) xv[b.idx - SLOT_X] = b.val;
			else if (b.idx < SLOT_END) pm[b.idx - SLOT_P] = b.val;
			return 0;
		end
		slice(SLOT_A, NN, a); slice(SLOT_C, N, c);
		slice(SLOT_Q, NN, q); slice(SLOT_G, NN, g);
		at = new[NN]; gt = new[NN];
		for (int i = 0; i < N; i++)
			for (int j = 0; j < N; j++) begin
				at[j*N+i] = a[i*N+j];
				gt[j*N+i] = g[i*N+j];
			end
		x = new[N]; p = new[NN];
		foreach (xv[i]) x[i] = xv[i];
		foreach (pm[i]) p[i] = pm[i];
		// predict
		mmul(a, x, xp, N, N, 1);
		mmul(a, p, ap, N, N, N);
		mmul(ap, at, apat, N, N, N);
		mmul(g, q, gq, N, N, N);
		mmul(gq, gt, gqg, N, N, N);
		pp = new[NN];
		for (int i = 0; i < NN; i++) pp[i] = sat(longint'(apat[i]) + longint'(gqg[i]));
		// innovate
		mmul(c, xp, cx, 1, N, 1);
		y = sat(longint'(b.meas) - longint'(cx[0]));
		mmul(c, pp, cp, 1, N, N);
		mmul(cp, c, cpc, 1, N, 1);
		s = sat(longint'(cpc[0]) + longint'(mdl[SLOT_R]));
		if (s <= 0) begin
			foreach (xv[i]) xv[i] = xp[i];
			foreach (pm[i]) pm[i] = pp[i];
			e.status = STAT_SKIP;
		end else begin
			// correct
			mmul(pp, c, pct, N, N, 1);
			kg = new[N];
			for (int i = 0; i < N; i++) begin
				num = longint'(pct[i]) * (longint'(1) << FRAC_BITS);
				kg[i] = sat(num / longint'(s));
			end
			for (int i = 0; i < N; i++)
				xv[i] = sat(longint'(sat(fmul(kg[i], y))) + longint'(xp[i]));
			mmul(kg, c, kc, N, 1, N);
			ikc = new[NN];
			for (int i = 0; i < N; i++)
				for (int j = 0; j < N; j++)
					ikc[i*N+j] = sat(((i == j) ? longint'(ONE) : 0) - longint'(kc[i*N+j]));
			mmul(ikc, pp, np, N, N, N);
			foreach (pm[i]) pm[i] = np[i];
			e.status = STAT_DONE;
		end
		e.e0 = xv[0]; e.e1 = xv[1]; e.e2 = xv[2];
		return 1;
	endfunction

	function automatic beat_t ld(int idx, logic signed [31:0] v);
		beat_t b;
		b.mode = MODE_LOAD; b.idx = 6'(idx); b.val = v; b.meas = $urandom;
		return b;
	endfunction

	function automatic beat_t meas(logic signed [31:0] z);
		beat_t b;
		b.mode = MODE_MEAS; b.idx = 6'($urandom); b.val = $urandom; b.meas = z;
		return b;
	endfunction

	function automatic logic signed [31:0] rnd_small();
		return $signed($urandom_range(0, 2 * 65536 * 4)) - 65536 * 4;
	endfunction

	// Random model load: mostly near-identity dynamics, sometimes wild values
	function automatic beat_t rnd_load();
		int idx;
		logic signed [31:0] v;
		idx = $urandom_range(0, 63);
		case ($urandom_range(0, 9))
			0: v = $urandom;
			1: v = ($urandom & 1) ? QMAX : QMIN;
			default: begin
				v = rnd_small() >>> $urandom_range(0, 3);
				if (idx < SLOT_C && idx % (N + 1) == 0) v = ONE + (v >>> 4);
			end
		endcase
		return ld(idx, v);
	endfunction

	// Directed table
	row_t dir_tab [$];
	function automatic row_t row(beat_t b, bit typed = 0, logic signed [31:0] e0 = 0,
			logic signed [31:0] e1 = 0, logic signed [31:0] e2 = 0, logic st = 0);
		row_t r;
		r.b = b; r.typed = typed;
		r.e.e0 = e0; r.e.e1 = e1; r.e.e2 = e2; r.e.status = st;
		return r;
	endfunction

	task automatic build_table();
		// after reset S is zero: skipped, all zero
		dir_tab.push_back(row(meas(QMAX), 1, 0, 0, 0, STAT_SKIP));
		dir_tab.push_back(row(ld(SLOT_X, QMAX)));
		dir_tab.push_back(row(ld(SLOT_X + 1, QMIN)));
		// out-of-range slot is ignored
		dir_tab.push_back(row(ld(SLOT_END, ONE)));
		dir_tab.push_back(row(ld(63, QMIN)));
		// zero A: prediction zero, S still zero
		dir_tab.push_back(row(meas(QMIN), 1, 0, 0, 0, STAT_SKIP));
		// negative R: skipped
		dir_tab.push_back(row(ld(SLOT_R, QMIN)));
		dir_tab.push_back(row(meas(ONE), 1, 0, 0, 0, STAT_SKIP));
		// identity A with a velocity term, C picks position, unit R, noise through G and Q
		for (int i = 0; i < N; i++) dir_tab.push_back(row(ld(SLOT_A + i*N + i, ONE)));
		dir_tab.push_back(row(ld(SLOT_A + 1, ONE)));
		dir_tab.push_back(row(ld(SLOT_C, ONE)));
		dir_tab.push_back(row(ld(SLOT_R, ONE)));
		dir_tab.push_back(row(ld(SLOT_Q, ONE >>> 2)));
		dir_tab.push_back(row(ld(SLOT_G, ONE)));
		dir_tab.push_back(row(ld(SLOT_P, ONE)));
		dir_tab.push_back(row(ld(SLOT_X, 0)));
		dir_tab.push_back(row(ld(SLOT_X + 1, 0)));
		dir_tab.push_back(row(meas(ONE * 3)));
		dir_tab.push_back(row(meas(QMAX)));
		dir_tab.push_back(row(meas(QMIN)));
		dir_tab.push_back(row(ld(SLOT_P + NN - 1, QMAX)));
		dir_tab.push_back(row(meas(-ONE)));
	endtask

	// Sender
	initial begin
		beat_t b;
		int gap;
		in_valid = 0; mode = MODE_LOAD; coef_index = 0; coef_value = 0; measurement = 0;
		arst_n = 0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1;
		build_table();
		foreach (dir_tab[i]) stim_q.push_back(dir_tab[i].b);
		for (int i = 0; i < N_RANDOM; i++) begin
			if ($urandom_range(0, 2) == 0) b = meas($urandom_range(0, 3) == 0 ? $urandom
				: rnd_small() <<< 2);
			else b = rnd_load();
			stim_q.push_back(b);
		end
		for (int i = 0; i < stim_q.size(); i++) begin
			if (i == dir_tab.size() + 100) hold_req = 1;
			in_valid <= 1;
			mode <= stim_q[i].mode; coef_index <= stim_q[i].idx;
			coef_value <= stim_q[i].val; measurement <= stim_q[i].meas;
			@(posedge clk);
			while (in_stall) @(posedge clk);
			@(negedge clk);
			// draw the gap before the next beat; drop valid only across a gap or after the last beat
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, IDLE_MAX);
			if (((i + 1) % 200) < 20) gap = 0;
			if (gap > 0 || i + 1 == stim_q.size()) in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		stim_done = 1;
	end

	// Predict on accepted input beats
	always @(posedge clk) begin
		estimate_t e;
		int n_in;
		if (arst_n && in_valid && !in_stall) begin
			n_in = n_accept;
			if (filter_step(stim_q[n_in], e)) begin
				if (n_in < dir_tab.size() && dir_tab[n_in].typed) begin
					if (e !== dir_tab[n_in].e) begin
						$display("%t directed row %0d: expected %p, model %p", $time, n_in,
							dir_tab[n_in].e, e);
						errors++;
					end
					e = dir_tab[n_in].e;
				end
				expected_q.push_back(e);
			end
			n_accept <= n_accept + 1;
		end
	end

	// Receiver: random stalls, one long hold-off
	initial begin
		int gap;
		bit hold_done;
		hold_done = 0;
		out_stall = 0;
		@(posedge arst_n);
		forever begin
			if (hold_req && !hold_done) begin
				hold_done = 1;
				@(negedge clk) out_stall <= 1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, IDLE_MAX);
			@(negedge clk) out_stall <= (gap != 0);
			repeat (gap > 0 ? gap - 1 : 0) @(negedge clk);
			@(negedge clk) out_stall <= 0;
			@(posedge clk);
			while (!(out_valid && !out_stall)) @(posedge clk);
		end
	end

	// Check result beats
	always @(posedge clk) begin
		estimate_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got.e0 = estimate_first; got.e1 = estimate_second;
			got.e2 = estimate_third; got.status = update_status;
			if (expected_q.size() == 0) begin
				$display("%t unexpected estimate beat %p", $time, got);
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (got.e0 !== want.e0) begin
					$display("%t estimate_first expected %0d actual %0d", $time, want.e0, got.e0);
					errors++;
				end
				if (got.e1 !== want.e1) begin
					$display("%t estimate_second expected %0d actual %0d", $time, want.e1, got.e1);
					errors++;
				end
				if (got.e2 !== want.e2) begin
					$display("%t estimate_third expected %0d actual %0d", $time, want.e2, got.e2);
					errors++;
				end
				if (got.status !== want.status) begin
					$display("%t update_status expected %0d actual %0d", $time, want.status,
						got.status);
					errors++;
				end
			end
		end
	end

	// Watchdog and end of run
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) dog <= 0;
		else dog <= dog + 1;
	end

	initial begin
		@(posedge arst_n);
		while (!(stim_done && expected_q.size() == 0) && dog < DOG_LIMIT) @(posedge clk);
		if (dog < DOG_LIMIT) repeat (2000) @(posedge clk);
		if (dog >= DOG_LIMIT) begin
			$display("Some tests failed");
		end else if (errors == 0 && expected_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
